### rtl/core/gauss_5x5_image_filter_unit_defines.svh
// ----------------------------------------------------------------------------
// gauss_5x5_image_filter_unit_defines.svh
// Assertion macros shared by the 5x5 Gaussian filter RTL.
// ----------------------------------------------------------------------------
`ifndef GAUSS_5X5_IMAGE_FILTER_UNIT_DEFINES_SVH
`define GAUSS_5X5_IMAGE_FILTER_UNIT_DEFINES_SVH

// same-cycle implication
`define G5F_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define G5F_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/g5f_pkg.sv
// ----------------------------------------------------------------------------
// g5f_pkg
// Shared types and constants of the 5x5 Gaussian image filter.
// ----------------------------------------------------------------------------
package g5f_pkg;

    localparam int PIX_W         = 8;
    localparam int COORD_W       = 10;
    localparam int CFG_W         = 11;
    localparam int CFG_IDX_W     = 2;
    localparam int MASK_SIZE     = 5;
    localparam int LINES         = MASK_SIZE - 1;
    localparam int LANE_W        = $clog2(LINES);
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int OUT_TDATA_W   = 32;

    localparam int KERNEL_TOTAL  = 330;
    localparam int KERN_W        = 6;
    localparam int ROW_SUM_W     = 16;
    localparam int SUM_W         = 17;
    // floor(sum / 330) ~= (sum * RECIP_M) >> RECIP_SHIFT, low by at most one
    localparam int RECIP_SHIFT   = 24;
    localparam int RECIP_W       = 16;
    localparam int RECIP_M       = (1 << RECIP_SHIFT) / KERNEL_TOTAL;
    localparam int Q_W           = 9;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

    localparam logic [KERN_W-1:0] KERNEL [MASK_SIZE][MASK_SIZE] = '{
        '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
        '{6'd4, 6'd20, 6'd33, 6'd20, 6'd4},
        '{6'd7, 6'd33, 6'd54, 6'd33, 6'd7},
        '{6'd4, 6'd20, 6'd33, 6'd20, 6'd4},
        '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef logic [LANE_W-1:0] lane_t;

    typedef struct packed {
        logic  en;
        lane_t lane;
    } ls_ctrl_t;

endpackage

### rtl/core/g5f_line_store.sv
// ----------------------------------------------------------------------------
// g5f_line_store
// Four line memories, one per stored row; all read at one column, one written.
// ----------------------------------------------------------------------------
module g5f_line_store #(
    parameter int  MAX_WIDTH = g5f_pkg::DEF_MAX_WIDTH,
    localparam int AW        = $clog2(MAX_WIDTH)
) (
    input  logic                                          clk,
    input  g5f_pkg::ls_ctrl_t                             ctrl,
    input  logic [AW-1:0]                                 addr,
    input  logic [g5f_pkg::PIX_W-1:0]                     wr_data,
    output logic [g5f_pkg::LINES-1:0][g5f_pkg::PIX_W-1:0] rd_data
);
    import g5f_pkg::*;

    for (genvar g = 0; g < LINES; g++)
    begin : g_lane
        logic [PIX_W-1:0] lane_mem [MAX_WIDTH];
        logic [PIX_W-1:0] rd_reg;

        // read-before-write at the same column
        always_ff @(posedge clk)
        begin
            if (ctrl.en)
            begin
                rd_reg <= lane_mem[addr];
                if (ctrl.lane == LANE_W'(g))
                begin
                    lane_mem[addr] <= wr_data;
                end
            end
        end

        assign rd_data[g] = rd_reg;
    end

endmodule

### rtl/core/gauss_5x5_image_filter_unit.sv
// ----------------------------------------------------------------------------
// gauss_5x5_image_filter_unit
// 5x5 Gaussian blur over a raster stream of 8-bit grey pixels.
//
// Takes one pixel per clock while the output is not stalled, and registers
// each result through line store read, window, row sums, total, reciprocal
// multiply and divide correction. The rate is set by the line store: one
// read per row lane and one write to one lane per clock at the pixel's column.
// A pixel whose 5x5 window lies fully inside the image gives one item with
// the kernel sum divided by 330 (truncated) and the window-centre column and
// row; border pixels give none. s_tuser flags the first pixel of a frame and
// restarts the counters; pixels past the configured height are dropped until
// the next frame start. Width and height are clamped to [5, MAX_WIDTH] and
// [5, 1024]. The line store is not cleared after reset and needs no warm-up.
// ----------------------------------------------------------------------------
`include "gauss_5x5_image_filter_unit_defines.svh"

module gauss_5x5_image_filter_unit #(
    parameter int MAX_WIDTH = g5f_pkg::DEF_MAX_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [g5f_pkg::PIX_W-1:0]         s_tdata,    // [7:0] pixel_value
    input  logic [0:0]                        s_tuser,    // [0] frame_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] filtered_pixel, [17:8] center_col, [27:18] center_row, [31:28] zero
    output logic [g5f_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [g5f_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [g5f_pkg::CFG_W-1:0]         cfg_data
);
    import g5f_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int PADW = OUT_TDATA_W - PIX_W - 2 * COORD_W;

    // configuration
    logic [CFG_W-1:0] img_w_reg;
    logic [CFG_W-1:0] img_h_reg;

    // frame position
    logic [CW-1:0]    col_cnt_reg;
    logic [CW-1:0]    col_cnt_next;
    logic [CFG_W-1:0] row_cnt_reg;
    logic [CFG_W-1:0] row_cnt_next;

    logic [CMPW-1:0]  w_use;
    logic [CFG_W-1:0] h_use;
    logic [CW-1:0]    col0;
    logic [CFG_W-1:0] row0;
    logic [CMPW-1:0]  col_inc;
    logic             in_frame;
    logic             accept;
    logic             has_res;

    // pipeline control
    logic load1, load2, load3, load4, load5, load_out;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic res1_reg, res2_reg, res3_reg, res4_reg, res5_reg;
    logic [CW-1:0]      col1_reg, col2_reg, col3_reg, col4_reg, col5_reg;
    logic [COORD_W-1:0] row1_reg, row2_reg, row3_reg, row4_reg, row5_reg;
    logic [PIX_W-1:0]   px1_reg;

    ls_ctrl_t                     ls_ctrl;
    logic [LINES-1:0][PIX_W-1:0]  ls_rd;

    logic [PIX_W-1:0] win_reg  [MASK_SIZE][MASK_SIZE];
    logic [PIX_W-1:0] col_in   [MASK_SIZE];

    logic [ROW_SUM_W-1:0] row_sum          [MASK_SIZE];
    logic [ROW_SUM_W-1:0] row_sum3_reg     [MASK_SIZE];
    logic [SUM_W-1:0]     sum_total;
    logic [SUM_W-1:0]     sum4_reg;
    logic [SUM_W-1:0]     sum5_reg;
    logic [SUM_W+RECIP_W-1:0] recip_prod;
    logic [Q_W-1:0]       q5_reg;
    logic [SUM_W:0]       div_back;
    logic [SUM_W:0]       div_rem;
    logic [Q_W-1:0]       q_fix;

    logic                 m_tvalid_reg;
    logic [PIX_W-1:0]     filt_reg;
    logic [COORD_W-1:0]   ccol_reg;
    logic [COORD_W-1:0]   crow_reg;

    // ---------------- front end: counters and line store access -------------
    always_comb
    begin
        w_use = CMPW'(img_w_reg);
        if (w_use < CMPW'(MASK_SIZE))
        begin
            w_use = CMPW'(MASK_SIZE);
        end
        else if (w_use > CMPW'(MAX_WIDTH))
        begin
            w_use = CMPW'(MAX_WIDTH);
        end

        h_use = img_h_reg;
        if (h_use < CFG_W'(MASK_SIZE))
        begin
            h_use = CFG_W'(MASK_SIZE);
        end
        else if (h_use > CFG_W'(MAX_HEIGHT))
        begin
            h_use = CFG_W'(MAX_HEIGHT);
        end
    end

    assign col0     = s_tuser[0] ? '0 : col_cnt_reg;
    assign row0     = s_tuser[0] ? '0 : row_cnt_reg;
    assign in_frame = (row0 < h_use);
    assign col_inc  = CMPW'(col0) + CMPW'(1);
    assign has_res  = (CMPW'(col0) >= CMPW'(LINES)) && (row0 >= CFG_W'(LINES));

    assign s_tready = load1;
    assign accept   = s_tvalid && load1;

    always_comb
    begin
        col_cnt_next = col0;
        row_cnt_next = row0;
        if (in_frame)
        begin
            if (col_inc >= w_use)
            begin
                col_cnt_next = '0;
                row_cnt_next = row0 + CFG_W'(1);
            end
            else
            begin
                col_cnt_next = CW'(col_inc);
            end
        end
    end

    assign ls_ctrl.en   = accept && in_frame;
    assign ls_ctrl.lane = lane_t'(row0);

    g5f_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .ctrl    (ls_ctrl),
        .addr    (col0),
        .wr_data (s_tdata),
        .rd_data (ls_rd)
    );

    // ---------------- pipeline flow ------------------------------------------
    assign load_out = !m_tvalid_reg || m_tready;
    assign load5    = !v5_reg || load_out;
    assign load4    = !v4_reg || load5;
    assign load3    = !v3_reg || load4;
    assign load2    = !v2_reg || load3;
    assign load1    = !v1_reg || load2;

    // new window column, oldest row first
    always_comb
    begin
        for (int k = 0; k < LINES; k++)
        begin
            col_in[k] = ls_rd[lane_t'(row1_reg[LANE_W-1:0] + lane_t'(k))];
        end
        col_in[MASK_SIZE-1] = px1_reg;
    end

    always_comb
    begin
        for (int r = 0; r < MASK_SIZE; r++)
        begin
            row_sum[r] = '0;
            for (int c = 0; c < MASK_SIZE; c++)
            begin
                row_sum[r] = row_sum[r]
                           + ROW_SUM_W'(KERNEL[r][c]) * ROW_SUM_W'(win_reg[r][c]);
            end
        end
    end

    always_comb
    begin
        sum_total = '0;
        for (int r = 0; r < MASK_SIZE; r++)
        begin
            sum_total = sum_total + SUM_W'(row_sum3_reg[r]);
        end
    end

    assign recip_prod = (SUM_W+RECIP_W)'(sum4_reg) * (SUM_W+RECIP_W)'(RECIP_M);

    assign div_back = (SUM_W+1)'(q5_reg) * (SUM_W+1)'(KERNEL_TOTAL);
    assign div_rem  = (SUM_W+1)'(sum5_reg) - div_back;
    assign q_fix    = (div_rem >= (SUM_W+1)'(KERNEL_TOTAL)) ? q5_reg + Q_W'(1) : q5_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg    <= CFG_RESET;
            img_h_reg    <= CFG_RESET;
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int r = 0; r < MASK_SIZE; r++)
            begin
                for (int c = 0; c < MASK_SIZE; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  img_w_reg <= cfg_data;
                    REG_IMAGE_HEIGHT: img_h_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
            end
            if (load1)
            begin
                v1_reg <= accept && in_frame;
            end
            if (load2)
            begin
                v2_reg <= v1_reg;
                if (v1_reg)
                begin
                    for (int r = 0; r < MASK_SIZE; r++)
                    begin
                        for (int c = 0; c < MASK_SIZE - 1; c++)
                        begin
                            win_reg[r][c] <= win_reg[r][c+1];
                        end
                        win_reg[r][MASK_SIZE-1] <= col_in[r];
                    end
                end
            end
            if (load3)
            begin
                v3_reg <= v2_reg;
            end
            if (load4)
            begin
                v4_reg <= v3_reg;
            end
            if (load5)
            begin
                v5_reg <= v4_reg;
            end
            if (load_out)
            begin
                m_tvalid_reg <= v5_reg && res5_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            res1_reg <= has_res;
            col1_reg <= col0;
            row1_reg <= COORD_W'(row0);
            px1_reg  <= s_tdata;
        end
        if (load2)
        begin
            res2_reg <= res1_reg;
            col2_reg <= col1_reg;
            row2_reg <= row1_reg;
        end
        if (load3)
        begin
            res3_reg <= res2_reg;
            col3_reg <= col2_reg;
            row3_reg <= row2_reg;
            for (int r = 0; r < MASK_SIZE; r++)
            begin
                row_sum3_reg[r] <= row_sum[r];
            end
        end
        if (load4)
        begin
            res4_reg <= res3_reg;
            col4_reg <= col3_reg;
            row4_reg <= row3_reg;
            sum4_reg <= sum_total;
        end
        if (load5)
        begin
            res5_reg <= res4_reg;
            col5_reg <= col4_reg;
            row5_reg <= row4_reg;
            sum5_reg <= sum4_reg;
            q5_reg   <= recip_prod[RECIP_SHIFT +: Q_W];
        end
        if (load_out)
        begin
            filt_reg <= PIX_W'(q_fix);
            ccol_reg <= COORD_W'(CMPW'(col5_reg) - CMPW'(MASK_SIZE / 2));
            crow_reg <= row5_reg - COORD_W'(MASK_SIZE / 2);
        end
    end

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {PADW'(0), crow_reg, ccol_reg, filt_reg};
    assign cfg_ready = 1'b1;

    // ---------------- assertions ---------------------------------------------
    `G5F_ASSERT_NXT(a_frame_restart, clk, rst_n, accept && s_tuser[0],
        col_cnt_reg == CW'(1) && row_cnt_reg == '0, "frame start did not restart counters")
    `G5F_ASSERT_IMP(a_div_estimate, clk, rst_n, v5_reg && res5_reg,
        div_rem < (SUM_W+1)'(2 * KERNEL_TOTAL), "reciprocal estimate off by more than one")
    `G5F_ASSERT_IMP(a_stall_only_full, clk, rst_n, !s_tready,
        m_tvalid && !m_tready && v1_reg && v5_reg, "input stalled with room in pipeline")

endmodule
